### rtl/sorted_multiset_table_core_macros.svh
// sorted_multiset_table_core_macros.svh
// assertion macros for the sorted multiset table checker
// no dependencies
`ifndef SORTED_MULTISET_TABLE_CORE_MACROS_SVH
`define SORTED_MULTISET_TABLE_CORE_MACROS_SVH

// same-cycle implication under the active-low reset
`define SMT_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("sorted multiset table check failed");

// next-cycle implication under the active-low reset
`define SMT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("sorted multiset table check failed");

`endif

### rtl/smt_pkg.sv
// smt_pkg.sv
// types, constants and cell commands shared by the sorted multiset table
// no dependencies
package smt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int GROUP       = 16;
    localparam int NGROUP      = (TABLE_DEPTH + GROUP - 1) / GROUP;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [OCC_W-1:0]          occ_t;

    localparam count_t COUNT_MAX = {COUNT_W{1'b1}};
    localparam occ_t   OCC_FULL  = OCC_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_CMP  = 3'd1,
        CELL_INC  = 3'd2,
        CELL_DEC  = 3'd3,
        CELL_INS  = 3'd4,
        CELL_DEL  = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        value_t   value;
    } cell_cmd_t;

endpackage

### rtl/smt_cell.sv
// smt_cell.sv
// one table entry: value, count and compare flags, shifts with its neighbors
// depends on smt_pkg
module smt_cell import smt_pkg::*; (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      live,
    input  value_t    prev_value,
    input  count_t    prev_count,
    input  logic      prev_ge,
    input  value_t    next_value,
    input  count_t    next_count,
    output value_t    value,
    output count_t    count,
    output logic      ge,
    output logic      eq
);

    value_t value_reg, value_next;
    count_t count_reg, count_next;
    logic   ge_reg, ge_next;
    logic   eq_reg, eq_next;

    always_comb begin
        value_next = value_reg;
        count_next = count_reg;
        ge_next    = ge_reg;
        eq_next    = eq_reg;
        case (cmd.op)
            CELL_CMP: begin
                ge_next = !(live && (value_reg < cmd.value));
                eq_next = live && (value_reg == cmd.value);
            end
            CELL_INC: begin
                if (eq_reg && count_reg != COUNT_MAX) begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            CELL_DEC: begin
                if (eq_reg) begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            CELL_INS: begin
                if (ge_reg && !prev_ge) begin
                    value_next = cmd.value;
                    count_next = COUNT_W'(1);
                end else if (prev_ge) begin
                    value_next = prev_value;
                    count_next = prev_count;
                end
            end
            CELL_DEL: begin
                if (ge_reg) begin
                    value_next = next_value;
                    count_next = next_count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        count_reg <= count_next;
        ge_reg    <= ge_next;
        eq_reg    <= eq_next;
    end

    assign value = value_reg;
    assign count = count_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

### rtl/smt_gather.sv
// smt_gather.sv
// two-level registered or-tree collecting the matching cell's count
// depends on smt_pkg
module smt_gather import smt_pkg::*; (
    input  logic                   aclk,
    input  logic [TABLE_DEPTH-1:0] eq,
    input  count_t                 counts [TABLE_DEPTH],
    output logic                   present,
    output count_t                 mult
);

    logic   grp_hit_reg [NGROUP];
    count_t grp_cnt_reg [NGROUP];
    logic   grp_hit_next [NGROUP];
    count_t grp_cnt_next [NGROUP];
    logic   present_reg, present_next;
    count_t mult_reg, mult_next;

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_hit_next[g] = 1'b0;
            grp_cnt_next[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < TABLE_DEPTH) begin
                    grp_hit_next[g] = grp_hit_next[g] | eq[g * GROUP + j];
                    grp_cnt_next[g] = grp_cnt_next[g]
                                    | (counts[g * GROUP + j] & {COUNT_W{eq[g * GROUP + j]}});
                end
            end
        end
    end

    always_comb begin
        present_next = 1'b0;
        mult_next    = '0;
        for (int g = 0; g < NGROUP; g++) begin
            present_next = present_next | grp_hit_reg[g];
            mult_next    = mult_next | grp_cnt_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_hit_reg[g] <= grp_hit_next[g];
            grp_cnt_reg[g] <= grp_cnt_next[g];
        end
        present_reg <= present_next;
        mult_reg    <= mult_next;
    end

    assign present = present_reg;
    assign mult    = mult_reg;

endmodule

### rtl/sorted_multiset_table_core.sv
// sorted_multiset_table_core.sv
// top level: sequencer, row of table cells, gather tree, result register
// depends on smt_pkg, smt_cell, smt_gather
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  input    | s_valid, s_ready  | s_mode, s_value
//  result   | m_valid, m_ready  | m_was_present, m_multiplicity, m_refused,
//           |                   | m_distinct_count
//
// one beat in flight: accept, compare, gather (GA, GB), then apply; no new beat until apply is done
// the gather states wait on the registered levels of the gather tree over the cell row
// s_ready returns once the apply cycle has loaded the result register
// a result stalled by m_ready holds the apply cycle until the register frees up
// aresetn clears occupancy and control; table contents need no reset
module sorted_multiset_table_core import smt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  mode_t  s_mode,
    input  value_t s_value,
    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_was_present,
    output count_t m_multiplicity,
    output logic   m_refused,
    output occ_t   m_distinct_count
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CMP   = 5'b00010,
        ST_GA    = 5'b00100,
        ST_GB    = 5'b01000,
        ST_APPLY = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg;
    value_t value_reg;
    occ_t   occ_reg, occ_next;
    logic   m_valid_reg, m_valid_next;
    logic   present_reg_o_reg;
    count_t mult_o_reg;
    logic   refused_o_reg;
    occ_t   dcount_o_reg;

    logic   present_reg;
    count_t mult_reg, mult_next;
    logic   refused_next;

    cell_cmd_t cmd;
    cell_op_t  apply_op;
    logic      out_free;
    logic      accept;

    value_t                 cell_value [TABLE_DEPTH];
    count_t                 cell_count [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_ge;
    logic [TABLE_DEPTH-1:0] cell_eq;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // result and table action from the gathered lookup
    always_comb begin
        apply_op     = CELL_HOLD;
        occ_next     = occ_reg;
        mult_next    = present_reg ? mult_reg : '0;
        refused_next = 1'b0;
        case (mode_reg)
            MODE_ADD: begin
                if (occ_reg == OCC_FULL) begin
                    refused_next = 1'b1;
                end else if (present_reg) begin
                    apply_op = CELL_INC;
                    if (mult_reg != COUNT_MAX) begin
                        mult_next = mult_reg + COUNT_W'(1);
                    end
                end else begin
                    apply_op  = CELL_INS;
                    occ_next  = occ_reg + OCC_W'(1);
                    mult_next = COUNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (present_reg) begin
                    if (mult_reg > COUNT_W'(1)) begin
                        apply_op  = CELL_DEC;
                        mult_next = mult_reg - COUNT_W'(1);
                    end else begin
                        apply_op  = CELL_DEL;
                        occ_next  = occ_reg - OCC_W'(1);
                        mult_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = CELL_HOLD;
        cmd.value    = value_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.op     = CELL_CMP;
                state_next = ST_GA;
            end
            ST_GA: begin
                state_next = ST_GB;
            end
            ST_GB: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    cmd.op       = apply_op;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_APPLY && out_free) begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            value_reg <= s_value;
        end
        if (state_reg == ST_APPLY && out_free) begin
            present_reg_o_reg <= present_reg;
            mult_o_reg        <= mult_next;
            refused_o_reg     <= refused_next;
            dcount_o_reg      <= occ_next;
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        value_t pv;
        count_t pc;
        logic   pg;
        value_t nv;
        count_t nc;

        if (i == 0) begin : g_first
            assign pv = '0;
            assign pc = '0;
            assign pg = 1'b0;
        end else begin : g_mid
            assign pv = cell_value[i-1];
            assign pc = cell_count[i-1];
            assign pg = cell_ge[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_last
            assign nv = '0;
            assign nc = '0;
        end else begin : g_body
            assign nv = cell_value[i+1];
            assign nc = cell_count[i+1];
        end

        smt_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .live       (OCC_W'(i) < occ_reg),
            .prev_value (pv),
            .prev_count (pc),
            .prev_ge    (pg),
            .next_value (nv),
            .next_count (nc),
            .value      (cell_value[i]),
            .count      (cell_count[i]),
            .ge         (cell_ge[i]),
            .eq         (cell_eq[i])
        );
    end

    smt_gather u_gather (
        .aclk    (aclk),
        .eq      (cell_eq),
        .counts  (cell_count),
        .present (present_reg),
        .mult    (mult_reg)
    );

    assign m_valid          = m_valid_reg;
    assign m_was_present    = present_reg_o_reg;
    assign m_multiplicity   = mult_o_reg;
    assign m_refused        = refused_o_reg;
    assign m_distinct_count = dcount_o_reg;

endmodule

### rtl/smt_checker.sv
// smt_checker.sv
// port-level checks for the sorted multiset table, bound to the top level
// depends on smt_pkg and sorted_multiset_table_core_macros.svh
`include "sorted_multiset_table_core_macros.svh"

module smt_checker import smt_pkg::*; (
    input logic   aclk,
    input logic   aresetn,
    input logic   s_valid,
    input logic   s_ready,
    input mode_t  s_mode,
    input value_t s_value,
    input logic   m_valid,
    input logic   m_ready,
    input logic   m_was_present,
    input count_t m_multiplicity,
    input logic   m_refused,
    input occ_t   m_distinct_count
);

    `SMT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_multiplicity) && $stable(m_distinct_count))
    `SMT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SMT_ASSERT_NOW(a_refused_full, aclk, aresetn, m_valid && m_refused, m_distinct_count == OCC_FULL)
    `SMT_ASSERT_NOW(a_count_needs_entry, aclk, aresetn, m_valid && m_multiplicity != '0, m_distinct_count != '0 && (m_was_present || !m_refused))

endmodule

bind sorted_multiset_table_core smt_checker u_smt_checker (.*);

### test/sorted_multiset_table_core_tb.sv
`timescale 1ns / 100ps
// sorted_multiset_table_core_tb.sv
// self-checking bench for sorted_multiset_table_core: queued beats, shadow table, scoreboard
// depends on smt_pkg and the sorted_multiset_table_core rtl
module sorted_multiset_table_core_tb;
    import smt_pkg::*;

    localparam int     QUIET_LIMIT   = 4000;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     TAIL_CYCLES   = 16;
    localparam value_t CROWDED_VALUE = 32'sh1234_5678;

    typedef struct packed {
        mode_t  mode;
        value_t value;
    } op_beat_t;

    typedef struct packed {
        logic   was_present;
        count_t multiplicity;
        logic   refused;
        occ_t   distinct_count;
    } table_outcome_t;

    logic   aclk;
    logic   aresetn          = 1'b0;
    logic   s_valid          = 1'b0;
    logic   s_ready;
    mode_t  s_mode           = MODE_ADD;
    value_t s_value          = '0;
    logic   m_valid;
    logic   m_ready          = 1'b0;
    logic   m_was_present;
    count_t m_multiplicity;
    logic   m_refused;
    occ_t   m_distinct_count;

    op_beat_t       op_queue[$];
    table_outcome_t outcome_fifo[$];

    value_t shadow_values[TABLE_DEPTH];
    count_t shadow_counts[TABLE_DEPTH];
    int     shadow_used = 0;

    int mismatches     = 0;
    int beats_accepted = 0;
    int total_ops      = 0;
    int quiet_cycles   = 0;

    op_beat_t next_op;
    int       burst_left = 0;
    int       gap_left   = 0;

    int rx_beats     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int pattern_left = 0;
    int stall_pct    = 0;

    table_outcome_t want;
    table_outcome_t predicted;

    sorted_multiset_table_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_was_present    (m_was_present),
        .m_multiplicity   (m_multiplicity),
        .m_refused        (m_refused),
        .m_distinct_count (m_distinct_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic queue_op(input mode_t m, input value_t v);
        op_queue.push_back('{mode: m, value: v});
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0: return value_t'($urandom_range(0, 31)) - value_t'(16);
            1: return value_t'(32'h8000_0000 + $urandom_range(0, 7));
            2: return value_t'(32'h7fff_ffff - $urandom_range(0, 7));
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic multiset_apply(input mode_t op, input value_t v, output table_outcome_t res);
        int     pos;
        int     i;
        logic   hit;
        count_t cnt;
        pos = 0;
        while (pos < shadow_used && shadow_values[pos] < v) pos++;
        hit = (pos < shadow_used) && (shadow_values[pos] == v);
        cnt = hit ? shadow_counts[pos] : '0;
        res.was_present = hit;
        res.refused     = 1'b0;
        case (op)
            MODE_ADD: begin
                if (shadow_used >= TABLE_DEPTH) begin
                    res.refused = 1'b1;
                end else if (hit) begin
                    if (cnt != COUNT_MAX) cnt++;
                    shadow_counts[pos] = cnt;
                end else begin
                    for (i = shadow_used; i > pos; i--) begin
                        shadow_values[i] = shadow_values[i-1];
                        shadow_counts[i] = shadow_counts[i-1];
                    end
                    shadow_values[pos] = v;
                    shadow_counts[pos] = count_t'(1);
                    shadow_used++;
                    cnt = count_t'(1);
                end
            end
            MODE_REMOVE: begin
                if (hit) begin
                    if (cnt > count_t'(1)) begin
                        cnt--;
                        shadow_counts[pos] = cnt;
                    end else begin
                        for (i = pos; i + 1 < shadow_used; i++) begin
                            shadow_values[i] = shadow_values[i+1];
                            shadow_counts[i] = shadow_counts[i+1];
                        end
                        shadow_used--;
                        cnt = '0;
                    end
                end
            end
            default: begin
                // query and spare code only report
            end
        endcase
        res.multiplicity   = cnt;
        res.distinct_count = occ_t'(shadow_used);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                next_op = op_queue.pop_front();
                s_valid <= 1'b1;
                s_mode  <= next_op.mode;
                s_value <= next_op.value;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 32);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        9: gap_left = $urandom_range(8, 24);
                        default: gap_left = $urandom_range(1, 5);
                    endcase
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) rx_beats++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && rx_beats >= 30) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(16, 160);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 75;
                    endcase
                end else begin
                    pattern_left--;
                end
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (outcome_fifo.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result beat: expected none, actual %0d/%0d/%0d/%0d",
                             $time, m_was_present, m_multiplicity, m_refused, m_distinct_count);
                end else begin
                    want = outcome_fifo.pop_front();
                    check_field("was_present", 32'(want.was_present), 32'(m_was_present));
                    check_field("multiplicity", 32'(want.multiplicity), 32'(m_multiplicity));
                    check_field("refused", 32'(want.refused), 32'(m_refused));
                    check_field("distinct_count", 32'(want.distinct_count),
                                32'(m_distinct_count));
                end
            end
            if (s_valid && s_ready) begin
                multiset_apply(s_mode, s_value, predicted);
                outcome_fifo.push_back(predicted);
                beats_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t no beat accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int       i;
        int       j;
        int       roll;
        value_t   v;
        value_t   tmp;
        value_t   placed[$];
        value_t   pool[6];
        mode_t    m;

        // directed
        queue_op(MODE_QUERY, 32'sd0);
        queue_op(MODE_REMOVE, 32'sh8000_0000);
        queue_op(MODE_ADD, 32'sh7fff_ffff);
        queue_op(MODE_ADD, 32'sh8000_0000);
        queue_op(MODE_ADD, 32'sd0);
        queue_op(MODE_ADD, -32'sd1);
        queue_op(MODE_ADD, 32'sd0);
        queue_op(MODE_QUERY, 32'sd0);
        queue_op(MODE_SPARE, 32'sd0);
        queue_op(MODE_SPARE, 32'sh5555_5555);
        queue_op(MODE_REMOVE, 32'sd0);
        queue_op(MODE_REMOVE, 32'sd0);
        queue_op(MODE_REMOVE, 32'sd0);
        queue_op(MODE_QUERY, -32'sd1);
        queue_op(MODE_ADD, 32'sd1);
        queue_op(MODE_REMOVE, 32'sh7fff_ffff);
        queue_op(MODE_REMOVE, 32'sh8000_0000);
        queue_op(MODE_QUERY, 32'sh7fff_ffff);
        queue_op(MODE_ADD, 32'shaaaa_aaaa);
        queue_op(MODE_REMOVE, -32'sd1);
        queue_op(MODE_REMOVE, 32'sd1);
        queue_op(MODE_REMOVE, 32'shaaaa_aaaa);

        // raise one count well above one, then step it down and up again
        repeat (40) queue_op(MODE_ADD, CROWDED_VALUE);
        queue_op(MODE_REMOVE, CROWDED_VALUE);
        queue_op(MODE_ADD, CROWDED_VALUE);
        queue_op(MODE_ADD, CROWDED_VALUE);

        // fill the table past capacity
        for (i = 0; i < 330; i++) begin
            v = pick_value();
            placed.push_back(v);
            queue_op(MODE_ADD, v);
            if (i % 8 == 7) queue_op(MODE_QUERY, placed[$urandom_range(0, placed.size() - 1)]);
        end
        queue_op(MODE_ADD, CROWDED_VALUE);
        for (i = 0; i < 24; i++) begin
            case ($urandom_range(0, 2))
                0: queue_op(MODE_ADD, placed[$urandom_range(0, placed.size() - 1)]);
                1: queue_op(MODE_ADD, value_t'($urandom));
                default: queue_op(MODE_QUERY, placed[$urandom_range(0, placed.size() - 1)]);
            endcase
        end
        queue_op(MODE_REMOVE, placed[0]);
        queue_op(MODE_ADD, value_t'($urandom));
        queue_op(MODE_ADD, value_t'($urandom));

        // drain in random order
        for (i = placed.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = placed[i];
            placed[i] = placed[j];
            placed[j] = tmp;
        end
        for (i = 0; i < placed.size(); i++) begin
            queue_op(MODE_REMOVE, placed[i]);
            if (i % 10 == 9) queue_op(mode_t'($urandom_range(0, 3)), value_t'($urandom));
        end
        queue_op(MODE_REMOVE, CROWDED_VALUE);

        // churn on small pools
        for (i = 0; i < 700; i++) begin
            if (i % 50 == 0) begin
                for (j = 0; j < 6; j++) pool[j] = pick_value();
            end
            roll = $urandom_range(0, 99);
            v = pool[$urandom_range(0, 5)];
            if (roll < 45) m = MODE_ADD;
            else if (roll < 80) m = MODE_REMOVE;
            else if (roll < 90) m = MODE_QUERY;
            else m = MODE_SPARE;
            queue_op(m, v);
        end

        // noise
        for (i = 0; i < 200; i++) queue_op(mode_t'($urandom_range(0, 3)), pick_value());

        total_ops = op_queue.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_accepted < total_ops || outcome_fifo.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
